### src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit heap allocator
// Table sizing, field widths, request and status codes, table entry layout.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 32;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W       = 24;
  localparam int SIZE_W       = 25;

  localparam logic [SIZE_W-1:0] CAP_LIMIT = 25'h100_0000;
  localparam logic [SIZE_W-1:0] CAP_RESET = 25'h010_0000;
  localparam logic [SIZE_W-1:0] RND_MASK  = 25'd15;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_CALLOC  = 2'd2;
  localparam logic [1:0] MODE_REALLOC = 2'd3;

  localparam logic [1:0] STAT_GRANTED = 2'd0;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### src/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl: request sequencer for the first-fit heap allocator
// Walks the block table in RAM for first-fit and address lookup, appends,
// marks and removes blocks, and keeps the entry count and heap top.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ffha_pkg::SIZE_W-1:0] cap,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [31:0]                 in_request_size,
  input  logic [31:0]                 in_element_count,
  input  logic [ffha_pkg::ADDR_W-1:0] in_payload_address,
  input  logic                        in_address_present,
  output logic                        ram_we,
  output logic [ffha_pkg::IDX_W-1:0]  ram_waddr,
  output logic [ffha_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [ffha_pkg::IDX_W-1:0]  ram_raddr,
  input  logic [ffha_pkg::ENTRY_W-1:0] ram_rdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [ffha_pkg::ADDR_W-1:0] out_result_address,
  output logic [ffha_pkg::SIZE_W-1:0] out_granted_size,
  output logic                        out_reused
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SCAN,
    S_RELEASE
  } state_t;

  typedef enum logic {
    K_FIT,
    K_LOOK
  } kind_t;

  localparam logic [ffha_pkg::SIZE_W-1:0] HDR     = ffha_pkg::SIZE_W'(ffha_pkg::HEADER_BYTES);
  localparam logic [ffha_pkg::CNT_W-1:0]  CNT_MAX = ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS);

  state_t                        state_r, state_nxt;
  kind_t                         kind_r, kind_nxt;
  logic [1:0]                    mode_r, mode_nxt;
  logic [31:0]                   size_r, size_nxt;
  logic [31:0]                   elem_r, elem_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [63:0]                   want_r, want_nxt;
  logic                          move_r, move_nxt;
  logic [ffha_pkg::CNT_W-1:0]    scan_r, scan_nxt;
  logic                          pend_vld_r, pend_vld_nxt;
  logic [ffha_pkg::IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [ffha_pkg::IDX_W-1:0]    lk_idx_r, lk_idx_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   lk_start_r, lk_start_nxt;
  logic [ffha_pkg::SIZE_W-1:0]   lk_size_r, lk_size_nxt;
  logic [ffha_pkg::CNT_W-1:0]    ecount_r, ecount_nxt;
  logic [ffha_pkg::SIZE_W-1:0]   top_r, top_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    res_status_r, res_status_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [ffha_pkg::SIZE_W-1:0]   res_size_r, res_size_nxt;
  logic                          res_reused_r, res_reused_nxt;

  ffha_pkg::entry_t              rd_e;
  ffha_pkg::entry_t              wr_e;
  logic [63:0]                   prod;
  logic                          want_big;
  logic [ffha_pkg::SIZE_W-1:0]   rounded;
  logic [ffha_pkg::SIZE_W:0]     need_sum;
  logic                          refuse_app;
  logic                          fit_hit;
  logic                          look_hit;
  logic                          hit;
  logic                          is_resize;
  logic [ffha_pkg::ADDR_W-1:0]   rd_payload;
  logic [ffha_pkg::CNT_W-1:0]    lk_next;

  assign rd_e       = ffha_pkg::entry_t'(ram_rdata);
  assign prod       = {32'd0, size_r} * {32'd0, elem_r};
  assign want_big   = (|want_r[63:25]) || (want_r[24] && (|want_r[23:0]));
  assign rounded    = (want_r[ffha_pkg::SIZE_W-1:0] + ffha_pkg::RND_MASK) & ~ffha_pkg::RND_MASK;
  assign need_sum   = {1'b0, top_r} + {1'b0, HDR} + {1'b0, rounded};
  assign refuse_app = want_big || (need_sum > {1'b0, cap}) || (ecount_r >= CNT_MAX);
  assign fit_hit    = rd_e.free && (rd_e.size >= rounded) && !want_big;
  assign look_hit   = ({1'b0, rd_e.start} + HDR) == {1'b0, addr_r};
  assign hit        = pend_vld_r && ((kind_r == K_FIT) ? fit_hit : look_hit);
  assign is_resize  = (mode_r == ffha_pkg::MODE_REALLOC) && (size_r != 32'd0);
  assign rd_payload = rd_e.start + ffha_pkg::ADDR_W'(ffha_pkg::HEADER_BYTES);
  assign lk_next    = ffha_pkg::CNT_W'({1'b0, lk_idx_r}) + ffha_pkg::CNT_W'(1);
  assign ram_raddr  = scan_r[ffha_pkg::IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    mode_nxt       = mode_r;
    size_nxt       = size_r;
    elem_nxt       = elem_r;
    addr_nxt       = addr_r;
    want_nxt       = want_r;
    move_nxt       = move_r;
    scan_nxt       = scan_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    lk_idx_nxt     = lk_idx_r;
    lk_start_nxt   = lk_start_r;
    lk_size_nxt    = lk_size_r;
    ecount_nxt     = ecount_r;
    top_nxt        = top_r;
    out_valid_nxt  = 1'b0;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_size_nxt   = res_size_r;
    res_reused_nxt = res_reused_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_idx_r;
    wr_e           = rd_e;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt       = in_mode;
          size_nxt       = in_request_size;
          elem_nxt       = in_element_count;
          addr_nxt       = in_payload_address;
          want_nxt       = {32'd0, in_request_size};
          move_nxt       = 1'b0;
          scan_nxt       = '0;
          pend_vld_nxt   = 1'b0;
          res_status_nxt = ffha_pkg::STAT_REFUSED;
          res_addr_nxt   = '0;
          res_size_nxt   = '0;
          res_reused_nxt = 1'b0;
          case (in_mode)
            ffha_pkg::MODE_ALLOC: begin
              if (in_request_size == 32'd0) begin
                out_valid_nxt = 1'b1;
              end else begin
                kind_nxt  = K_FIT;
                state_nxt = S_SCAN;
              end
            end
            ffha_pkg::MODE_CALLOC: begin
              if (in_request_size == 32'd0 || in_element_count == 32'd0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_MUL;
              end
            end
            default: begin
              if (in_mode == ffha_pkg::MODE_REALLOC && in_request_size != 32'd0) begin
                kind_nxt  = in_address_present ? K_LOOK : K_FIT;
                state_nxt = S_SCAN;
              end else if (!in_address_present) begin
                res_status_nxt = ffha_pkg::STAT_DONE;
                out_valid_nxt  = 1'b1;
              end else begin
                kind_nxt  = K_LOOK;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_MUL: begin
        want_nxt  = prod;
        kind_nxt  = K_FIT;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (hit) begin
          if (kind_r == K_FIT) begin
            ram_we         = 1'b1;
            ram_waddr      = pend_idx_r;
            wr_e.free      = 1'b0;
            res_status_nxt = ffha_pkg::STAT_GRANTED;
            res_addr_nxt   = rd_payload;
            res_size_nxt   = rd_e.size;
            res_reused_nxt = 1'b1;
            if (move_r) begin
              state_nxt = S_RELEASE;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else begin
            lk_idx_nxt   = pend_idx_r;
            lk_start_nxt = rd_e.start;
            lk_size_nxt  = rd_e.size;
            if (!is_resize) begin
              res_status_nxt = ffha_pkg::STAT_DONE;
              state_nxt      = S_RELEASE;
            end else if ({7'd0, rd_e.size} >= size_r) begin
              res_status_nxt = ffha_pkg::STAT_GRANTED;
              res_addr_nxt   = addr_r;
              res_size_nxt   = rd_e.size;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              move_nxt     = 1'b1;
              kind_nxt     = K_FIT;
              scan_nxt     = '0;
              pend_vld_nxt = 1'b0;
            end
          end
        end else if (scan_r < ecount_r) begin
          scan_nxt     = scan_r + ffha_pkg::CNT_W'(1);
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = scan_r[ffha_pkg::IDX_W-1:0];
        end else begin
          pend_vld_nxt = 1'b0;
          if (kind_r == K_LOOK) begin
            res_status_nxt = ffha_pkg::STAT_UNKNOWN;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else if (refuse_app) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = ecount_r[ffha_pkg::IDX_W-1:0];
            wr_e.start     = top_r[ffha_pkg::ADDR_W-1:0];
            wr_e.size      = rounded;
            wr_e.free      = 1'b0;
            ecount_nxt     = ecount_r + ffha_pkg::CNT_W'(1);
            top_nxt        = need_sum[ffha_pkg::SIZE_W-1:0];
            res_status_nxt = ffha_pkg::STAT_GRANTED;
            res_addr_nxt   = top_r[ffha_pkg::ADDR_W-1:0] +
                             ffha_pkg::ADDR_W'(ffha_pkg::HEADER_BYTES);
            res_size_nxt   = rounded;
            res_reused_nxt = 1'b0;
            if (move_r) begin
              state_nxt = S_RELEASE;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        end
      end

      S_RELEASE: begin
        if (lk_next == ecount_r) begin
          top_nxt    = top_r - (HDR + lk_size_r);
          ecount_nxt = ecount_r - ffha_pkg::CNT_W'(1);
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = lk_idx_r;
          wr_e.start = lk_start_r;
          wr_e.size  = lk_size_r;
          wr_e.free  = 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_wdata = wr_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_vld_r  <= 1'b0;
      ecount_r    <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      ecount_r    <= ecount_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    mode_r       <= mode_nxt;
    size_r       <= size_nxt;
    elem_r       <= elem_nxt;
    addr_r       <= addr_nxt;
    want_r       <= want_nxt;
    move_r       <= move_nxt;
    scan_r       <= scan_nxt;
    pend_idx_r   <= pend_idx_nxt;
    lk_idx_r     <= lk_idx_nxt;
    lk_start_r   <= lk_start_nxt;
    lk_size_r    <= lk_size_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_size_r   <= res_size_nxt;
    res_reused_r <= res_reused_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = res_status_r;
  assign out_result_address = res_addr_r;
  assign out_granted_size   = res_size_r;
  assign out_reused         = res_reused_r;

endmodule

### src/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator
// Block table held in one RAM; allocate, free, calloc and realloc requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request beat: drive in_* and raise start; it is taken at a rising edge
//   with start high and busy low. One result beat follows per request, on
//   out_* for one cycle with out_valid high; the receiver cannot stall it.
//   Requests settled at once (zero size, null free) answer from idle;
//   others walk the table, after a multiply step for calloc and followed by
//   a release step for a free or a move. A realloc that moves walks twice.
//   The walk reads one table entry per cycle from the single RAM read port.
//   The next request may start in the cycle its predecessor's result shows.
//   cfg_we writes heap_capacity (saturated to 16 MiB); the user must raise
//   it only while idle, as the block itself has no check for that.
//   Reset: entry count, heap top and control clear; capacity returns to
//   1 MiB. Table RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [31:0]                 in_request_size,
  input  logic [31:0]                 in_element_count,
  input  logic [ffha_pkg::ADDR_W-1:0] in_payload_address,
  input  logic                        in_address_present,
  input  logic                        cfg_we,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_wdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [ffha_pkg::ADDR_W-1:0] out_result_address,
  output logic [ffha_pkg::SIZE_W-1:0] out_granted_size,
  output logic                        out_reused
);

  logic [ffha_pkg::SIZE_W-1:0]  cap_r, cap_nxt;
  logic                         ram_we;
  logic [ffha_pkg::IDX_W-1:0]   ram_waddr;
  logic [ffha_pkg::ENTRY_W-1:0] ram_wdata;
  logic [ffha_pkg::IDX_W-1:0]   ram_raddr;
  logic [ffha_pkg::ENTRY_W-1:0] ram_rdata;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      cap_nxt = (cfg_wdata > ffha_pkg::CAP_LIMIT) ? ffha_pkg::CAP_LIMIT : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ffha_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  ffha_ram #(
    .WIDTH (ffha_pkg::ENTRY_W),
    .DEPTH (ffha_pkg::MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffha_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cap                (cap_r),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_request_size    (in_request_size),
    .in_element_count   (in_element_count),
    .in_payload_address (in_payload_address),
    .in_address_present (in_address_present),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_granted_size   (out_granted_size),
    .out_reused         (out_reused)
  );

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result beat without a request");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ffha_pkg::STAT_GRANTED) |->
      (out_result_address == '0 && out_granted_size == '0 && !out_reused))
    else $error("non-grant result carries address or size");
`endif

endmodule

### sim/ffha_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffha_tb_pkg: shadow heap table and result checker for the allocator bench
// Keeps its own copy of the block table, heap top and capacity. It predicts
// the result of every accepted request beat and compares the result beats
// against those predictions in order.
// ----------------------------------------------------------------------------
package ffha_tb_pkg;

  import ffha_pkg::*;

  typedef struct packed {
    logic [1:0]        mode;
    logic [31:0]       request_size;
    logic [31:0]       element_count;
    logic [ADDR_W-1:0] payload_address;
    logic              address_present;
  } heap_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic [SIZE_W-1:0] granted_size;
    logic              reused;
  } heap_reply_t;

  class heap_shadow;
    logic [SIZE_W-1:0] capacity;
    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    int                blk_count;
    logic [SIZE_W-1:0] top;
    heap_reply_t       replies_due [$];
    int unsigned       mismatches;

    function new();
      capacity   = CAP_RESET;
      blk_count  = 0;
      top        = '0;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [SIZE_W-1:0] value);
      capacity = (value > CAP_LIMIT) ? CAP_LIMIT : value;
    endfunction

    function heap_reply_t make_reply(logic [1:0] st, logic [ADDR_W-1:0] a,
                                     logic [SIZE_W-1:0] sz, logic ru);
      heap_reply_t r;
      r.status         = st;
      r.result_address = a;
      r.granted_size   = sz;
      r.reused         = ru;
      return r;
    endfunction

    function heap_reply_t grant_block(longint unsigned want);
      longint unsigned rounded;
      logic [ADDR_W-1:0] base;
      if (want == 0) return make_reply(STAT_REFUSED, '0, '0, 1'b0);
      rounded = (want + 64'd15) & ~64'd15;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && {39'd0, blk_size[i]} >= rounded) begin
          blk_free[i] = 1'b0;
          base = blk_start[i] + ADDR_W'(HEADER_BYTES);
          return make_reply(STAT_GRANTED, base, blk_size[i], 1'b1);
        end
      end
      if (rounded > {39'd0, capacity} ||
          {39'd0, top} + 64'(HEADER_BYTES) + rounded > {39'd0, capacity} ||
          blk_count >= MAX_BLOCKS)
        return make_reply(STAT_REFUSED, '0, '0, 1'b0);
      blk_start[blk_count] = top[ADDR_W-1:0];
      blk_size[blk_count]  = rounded[SIZE_W-1:0];
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      top  = top + SIZE_W'(HEADER_BYTES) + rounded[SIZE_W-1:0];
      base = blk_start[blk_count-1] + ADDR_W'(HEADER_BYTES);
      return make_reply(STAT_GRANTED, base, rounded[SIZE_W-1:0], 1'b0);
    endfunction

    function int find_block(logic [ADDR_W-1:0] a);
      for (int i = 0; i < blk_count; i++)
        if ({1'b0, blk_start[i]} + SIZE_W'(HEADER_BYTES) == {1'b0, a}) return i;
      return -1;
    endfunction

    function void drop_block(int idx);
      if (idx + 1 == blk_count) begin
        top = top - SIZE_W'(HEADER_BYTES) - blk_size[idx];
        blk_count--;
      end else begin
        blk_free[idx] = 1'b1;
      end
    endfunction

    function heap_reply_t release_payload(logic present, logic [ADDR_W-1:0] a);
      int idx;
      if (!present) return make_reply(STAT_DONE, '0, '0, 1'b0);
      idx = find_block(a);
      if (idx < 0) return make_reply(STAT_UNKNOWN, '0, '0, 1'b0);
      drop_block(idx);
      return make_reply(STAT_DONE, '0, '0, 1'b0);
    endfunction

    function void note_request(heap_req_t q);
      heap_reply_t r;
      int idx;
      case (q.mode)
        MODE_ALLOC: r = grant_block({32'd0, q.request_size});
        MODE_FREE: r = release_payload(q.address_present, q.payload_address);
        MODE_CALLOC: begin
          if (q.request_size == 0 || q.element_count == 0)
            r = make_reply(STAT_REFUSED, '0, '0, 1'b0);
          else
            r = grant_block({32'd0, q.request_size} * {32'd0, q.element_count});
        end
        default: begin
          if (q.request_size == 0) begin
            r = release_payload(q.address_present, q.payload_address);
          end else if (!q.address_present) begin
            r = grant_block({32'd0, q.request_size});
          end else begin
            idx = find_block(q.payload_address);
            if (idx < 0) begin
              r = make_reply(STAT_UNKNOWN, '0, '0, 1'b0);
            end else if ({7'd0, blk_size[idx]} >= q.request_size) begin
              r = make_reply(STAT_GRANTED, q.payload_address, blk_size[idx], 1'b0);
            end else begin
              r = grant_block({32'd0, q.request_size});
              if (r.status == STAT_GRANTED) drop_block(idx);
            end
          end
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(heap_reply_t got);
      heap_reply_t want;
      if (replies_due.size() == 0) begin
        $error("result beat with no request outstanding: status %0d address %0d",
               got.status, got.result_address);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.result_address !== want.result_address) begin
        $error("result_address: expected %0d, actual %0d",
               want.result_address, got.result_address);
        mismatches++;
      end
      if (got.granted_size !== want.granted_size) begin
        $error("granted_size: expected %0d, actual %0d",
               want.granted_size, got.granted_size);
        mismatches++;
      end
      if (got.reused !== want.reused) begin
        $error("reused: expected %0d, actual %0d", want.reused, got.reused);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function int live_blocks();
      return blk_count;
    endfunction

    function logic [ADDR_W-1:0] payload_at(int idx);
      return blk_start[idx] + ADDR_W'(HEADER_BYTES);
    endfunction
  endclass

endpackage

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: bench for the first-fit heap allocator
// Runs a directed set of requests covering the corner cases, then random
// request streams under several heap capacities, with random start gaps.
// Every result beat is checked against the shadow table in order.
// ----------------------------------------------------------------------------
module tb_top;

  import ffha_pkg::*;
  import ffha_tb_pkg::*;

  localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 40;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 134;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              start              = 1'b0;
  logic              busy;
  logic [1:0]        in_mode            = MODE_ALLOC;
  logic [31:0]       in_request_size    = '0;
  logic [31:0]       in_element_count   = '0;
  logic [ADDR_W-1:0] in_payload_address = '0;
  logic              in_address_present = 1'b0;
  logic              cfg_we             = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata          = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_result_address;
  logic [SIZE_W-1:0] out_granted_size;
  logic              out_reused;

  heap_shadow shadow;

  always #6 clk = ~clk;

  first_fit_heap_allocator_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_request_size    (in_request_size),
    .in_element_count   (in_element_count),
    .in_payload_address (in_payload_address),
    .in_address_present (in_address_present),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_granted_size   (out_granted_size),
    .out_reused         (out_reused)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      shadow.check_reply(heap_reply_t'({out_status, out_result_address,
                                        out_granted_size, out_reused}));
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send(heap_req_t q, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode            <= q.mode;
    in_request_size    <= q.request_size;
    in_element_count   <= q.element_count;
    in_payload_address <= q.payload_address;
    in_address_present <= q.address_present;
    start              <= 1'b1;
    do @(posedge clk); while (busy);
    shadow.note_request(q);
  endtask

  task automatic issue(logic [1:0] m, logic [31:0] sz, logic [31:0] cnt,
                       logic [ADDR_W-1:0] a, logic p);
    send('{m, sz, cnt, a, p}, $urandom_range(0, 18));
  endtask

  // hold off until every outstanding result beat has come and the block is idle
  task automatic idle_wait();
    if (shadow.pending() != 0 || busy) begin
      start <= 1'b0;
      do @(posedge clk); while (shadow.pending() != 0 || busy);
    end
  endtask

  task automatic write_capacity(logic [SIZE_W-1:0] value);
    idle_wait();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow.set_capacity(value);
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 32'($urandom_range(1, 256));
    if (r < 82) return 32'($urandom_range(257, 4096));
    if (r < 88) return 32'd0;
    if (r < 94) return $urandom;
    return 32'($urandom_range(0, shadow.capacity));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (shadow.live_blocks() == 0 || r >= 90) return ADDR_W'($urandom);
    a = shadow.payload_at($urandom_range(0, shadow.live_blocks() - 1));
    if (r >= 80) a = $urandom_range(0, 1) ? a + 24'd16 : a - 24'd16;
    return a;
  endfunction

  function automatic heap_req_t random_request(int unsigned alloc_pct);
    heap_req_t q;
    int unsigned r;
    q.mode            = MODE_ALLOC;
    q.request_size    = pick_size();
    q.element_count   = $urandom;
    q.payload_address = ADDR_W'($urandom);
    q.address_present = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 7) begin
      q.mode         = 2'($urandom_range(0, 3));
      q.request_size = $urandom;
      return q;
    end
    if ($urandom_range(0, 99) < alloc_pct) return q;
    r = $urandom_range(0, 99);
    q.payload_address = pick_address();
    q.address_present = ($urandom_range(0, 19) != 0);
    if (r < 45) begin
      q.mode = MODE_FREE;
    end else if (r < 80) begin
      q.mode = MODE_REALLOC;
    end else begin
      q.mode          = MODE_CALLOC;
      q.request_size  = 32'($urandom_range(0, 64));
      q.element_count = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : 32'($urandom_range(0, 64));
    end
    return q;
  endfunction

  initial begin
    int unsigned caps      [PHASES];
    int unsigned alloc_pct [PHASES];
    int unsigned gap;
    int unsigned burst_left;
    caps      = '{4096, CAP_LIMIT, 0, 25'h1FF_FFFF, CAP_RESET, 65536};
    alloc_pct = '{60, 80, 30, 75, 35, 55};
    burst_left = 0;
    shadow = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(MODE_ALLOC, 32'd0, 32'd0, '0, 1'b0);
    issue(MODE_ALLOC, 32'd1, 32'd0, '0, 1'b0);
    issue(MODE_ALLOC, 32'd16, 32'd0, '0, 1'b0);
    issue(MODE_ALLOC, 32'd17, 32'd0, '0, 1'b0);
    issue(MODE_FREE, 32'd0, 32'd0, '0, 1'b0);
    issue(MODE_FREE, 32'd0, 32'd0, 24'd5, 1'b1);
    issue(MODE_FREE, 32'd0, 32'd0, shadow.payload_at(1), 1'b1);
    issue(MODE_FREE, 32'd0, 32'd0, shadow.payload_at(1), 1'b1);
    issue(MODE_ALLOC, 32'd10, 32'd0, '0, 1'b0);
    issue(MODE_CALLOC, 32'd0, 32'd5, '0, 1'b0);
    issue(MODE_CALLOC, 32'd5, 32'd0, '0, 1'b0);
    issue(MODE_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0);
    issue(MODE_CALLOC, 32'd3, 32'd7, '0, 1'b0);
    issue(MODE_REALLOC, 32'd20, 32'd0, '0, 1'b0);
    issue(MODE_REALLOC, 32'd0, 32'd0, shadow.payload_at(shadow.live_blocks() - 1), 1'b1);
    issue(MODE_REALLOC, 32'd0, 32'd0, 24'h00_FFFF, 1'b1);
    issue(MODE_REALLOC, 32'd0, 32'd0, '0, 1'b0);
    issue(MODE_REALLOC, 32'd16, 32'd0, shadow.payload_at(1), 1'b1);
    issue(MODE_REALLOC, 32'd100, 32'd0, shadow.payload_at(1), 1'b1);
    issue(MODE_REALLOC, 32'd8, 32'd0, 24'hFF_FFFF, 1'b1);
    issue(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0, '0, 1'b0);
    issue(MODE_ALLOC, 32'(CAP_RESET), 32'd0, '0, 1'b0);
    issue(MODE_REALLOC, 32'h00FF_FFFF, 32'd0, shadow.payload_at(0), 1'b1);
    issue(MODE_FREE, 32'd0, 32'd0, shadow.payload_at(shadow.live_blocks() - 1), 1'b1);
    issue(MODE_CALLOC, 32'h0001_0000, 32'h0001_0000, '0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(SIZE_W'(caps[p]));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) idle_wait();
        if (burst_left != 0) begin
          gap = 0;
          burst_left--;
        end else begin
          if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 20);
          gap = $urandom_range(0, 18);
        end
        send(random_request(alloc_pct[p]), gap);
      end
    end

    idle_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
